### design/acfd_pkg.sv
// shared types and constants for the ascii command frame decoder
package acfd_pkg;

  // frame text capacity in characters
  localparam int unsigned FRAME_CHARS = 14;
  localparam int unsigned CNT_W       = $clog2(FRAME_CHARS + 1);

  // request queue between front and back
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam int unsigned NUM_FIELDS  = 4;
  localparam int unsigned FIDX_W      = 3;

  // character codes
  localparam logic [7:0] CH_END   = 8'h2E;
  localparam logic [7:0] CH_SEP   = 8'h3B;
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;

  // configuration register indexes and reset values
  localparam logic REG_ID_HIGH = 1'b0;
  localparam logic REG_ID_LOW  = 1'b1;
  localparam logic [7:0] ID_HIGH_RST = 8'h12;
  localparam logic [7:0] ID_LOW_RST  = 8'h80;

  // action codes
  localparam logic [1:0] ACT_NONE    = 2'd0;
  localparam logic [1:0] ACT_MEASURE = 2'd1;
  localparam logic [1:0] ACT_RESEND  = 2'd2;
  localparam logic [1:0] ACT_CLEAR   = 2'd3;

  // classified character as it travels from front to back
  typedef struct packed {
    logic       is_end;
    logic       is_nul;
    logic       is_sep;
    logic       is_space;
    logic       is_plus;
    logic       is_minus;
    logic       is_digit;
    logic [3:0] digit;
  } char_class_t;

endpackage

### design/acfd_front.sv
// front part: accepts received characters and classifies them
module acfd_front (
  input  logic                 in_valid,
  input  logic [7:0]           in_rx_char,
  output logic                 in_stall,
  input  logic                 q_full,
  output logic                 q_push,
  output acfd_pkg::char_class_t q_data
);
  import acfd_pkg::*;

  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;

  always_comb begin
    q_data.is_end   = (in_rx_char == CH_END);
    q_data.is_nul   = (in_rx_char == CH_NUL);
    q_data.is_sep   = (in_rx_char == CH_SEP);
    q_data.is_space = (in_rx_char == CH_SPACE) || (in_rx_char inside {[CH_TAB:CH_CR]});
    q_data.is_plus  = (in_rx_char == CH_PLUS);
    q_data.is_minus = (in_rx_char == CH_MINUS);
    q_data.is_digit = (in_rx_char inside {[CH_ZERO:CH_NINE]});
    q_data.digit    = 4'(in_rx_char - CH_ZERO);
  end

endmodule

### design/acfd_queue.sv
// short request queue between front and back
module acfd_queue (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  acfd_pkg::char_class_t push_data,
  output logic                  full,
  input  logic                  pop,
  output logic                  head_valid,
  output acfd_pkg::char_class_t head_data
);
  import acfd_pkg::*;

  char_class_t         mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0]   cnt_r, cnt_nxt;
  logic                do_pop;

  assign full       = (cnt_r == QCNT_W'(QUEUE_DEPTH));
  assign head_valid = (cnt_r != '0);
  assign head_data  = mem_r[rd_ptr_r];
  assign do_pop     = pop && head_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : QPTR_W'(wr_ptr_r + 1'b1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : QPTR_W'(rd_ptr_r + 1'b1);
    end
    if (push && !do_pop) begin
      cnt_nxt = QCNT_W'(cnt_r + 1'b1);
    end else if (do_pop && !push) begin
      cnt_nxt = QCNT_W'(cnt_r - 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

### design/acfd_back.sv
// back part: token parsing, field store, frame check and result register
module acfd_back (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  head_valid,
  input  acfd_pkg::char_class_t head_data,
  output logic                  pop,
  input  logic [7:0]            id_high,
  input  logic [7:0]            id_low,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  out_checksum_ok,
  output logic                  out_id_match,
  output logic [7:0]            out_command,
  output logic [1:0]            out_action
);
  import acfd_pkg::*;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_LEAD = 2'd1,
    PH_NUM  = 2'd2,
    PH_DONE = 2'd3
  } phase_t;

  logic [7:0]        field_r [NUM_FIELDS];
  logic [7:0]        field_nxt [NUM_FIELDS];
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [FIDX_W-1:0] fidx_r, fidx_nxt;
  phase_t            phase_r, phase_nxt;
  logic              minus_r, minus_nxt;
  logic [7:0]        acc_r, acc_nxt;
  logic              ended_r, ended_nxt;

  logic              ovalid_r, ovalid_nxt;
  logic              ck_r, ck_nxt;
  logic              idm_r, idm_nxt;
  logic [7:0]        cmd_r, cmd_nxt;
  logic [1:0]        act_r, act_nxt;

  logic              slot_free;
  logic              take;
  logic              close_tok;
  logic [7:0]        tok_val;
  logic [7:0]        acc_x10;
  logic [7:0]        sum;
  phase_t            ph_eff;

  assign out_valid       = ovalid_r;
  assign out_checksum_ok = ck_r;
  assign out_id_match    = idm_r;
  assign out_command     = cmd_r;
  assign out_action      = act_r;

  assign slot_free = !ovalid_r || !out_stall;
  assign pop       = head_valid && (!head_data.is_end || slot_free);
  assign take      = pop;

  assign tok_val = minus_r ? 8'(~acc_r + 8'd1) : acc_r;
  assign acc_x10 = 8'({acc_r[4:0], 3'b000} + {acc_r[6:0], 1'b0});
  assign ph_eff  = (phase_r == PH_IDLE) ? PH_LEAD : phase_r;

  always_comb begin
    field_nxt  = field_r;
    cnt_nxt    = cnt_r;
    fidx_nxt   = fidx_r;
    phase_nxt  = phase_r;
    minus_nxt  = minus_r;
    acc_nxt    = acc_r;
    ended_nxt  = ended_r;
    ovalid_nxt = ovalid_r && out_stall;
    ck_nxt     = ck_r;
    idm_nxt    = idm_r;
    cmd_nxt    = cmd_r;
    act_nxt    = act_r;
    close_tok  = 1'b0;
    sum        = '0;

    if (take) begin
      if (head_data.is_end) begin
        close_tok = 1'b1;
      end else if (cnt_r < CNT_W'(FRAME_CHARS)) begin
        cnt_nxt = CNT_W'(cnt_r + 1'b1);
        if (!ended_r) begin
          if (head_data.is_nul) begin
            ended_nxt = 1'b1;
          end else if (head_data.is_sep) begin
            close_tok = 1'b1;
          end else begin
            phase_nxt = ph_eff;
            case (ph_eff)
              PH_LEAD: begin
                if (head_data.is_space) begin
                  phase_nxt = PH_LEAD;
                end else if (head_data.is_plus) begin
                  phase_nxt = PH_NUM;
                end else if (head_data.is_minus) begin
                  minus_nxt = 1'b1;
                  phase_nxt = PH_NUM;
                end else if (head_data.is_digit) begin
                  acc_nxt   = {4'd0, head_data.digit};
                  phase_nxt = PH_NUM;
                end else begin
                  phase_nxt = PH_DONE;
                end
              end
              PH_NUM: begin
                if (head_data.is_digit) begin
                  acc_nxt = 8'(acc_x10 + {4'd0, head_data.digit});
                end else begin
                  phase_nxt = PH_DONE;
                end
              end
              default: begin
              end
            endcase
          end
        end
      end
    end

    if (close_tok) begin
      if (phase_r != PH_IDLE && fidx_r < FIDX_W'(NUM_FIELDS)) begin
        field_nxt[fidx_r[1:0]] = tok_val;
        fidx_nxt = FIDX_W'(fidx_r + 1'b1);
      end
      phase_nxt = PH_IDLE;
      minus_nxt = 1'b0;
      acc_nxt   = '0;
    end

    if (take && head_data.is_end) begin
      // frame check on the fields as they stand after the last token
      sum        = 8'(field_nxt[0] + field_nxt[1] + field_nxt[2]);
      ck_nxt     = (sum == field_nxt[3]);
      idm_nxt    = (field_nxt[0] == id_high) && (field_nxt[1] == id_low);
      cmd_nxt    = field_nxt[2];
      act_nxt    = ACT_NONE;
      if (ck_nxt && idm_nxt && (field_nxt[2] == {6'd0, ACT_MEASURE} ||
          field_nxt[2] == {6'd0, ACT_RESEND} || field_nxt[2] == {6'd0, ACT_CLEAR})) begin
        act_nxt = field_nxt[2][1:0];
      end
      ovalid_nxt = 1'b1;
      cnt_nxt    = '0;
      fidx_nxt   = '0;
      ended_nxt  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_FIELDS; i++) begin
        field_r[i] <= '0;
      end
      cnt_r    <= '0;
      fidx_r   <= '0;
      phase_r  <= PH_IDLE;
      minus_r  <= 1'b0;
      acc_r    <= '0;
      ended_r  <= 1'b0;
      ovalid_r <= 1'b0;
    end else begin
      field_r  <= field_nxt;
      cnt_r    <= cnt_nxt;
      fidx_r   <= fidx_nxt;
      phase_r  <= phase_nxt;
      minus_r  <= minus_nxt;
      acc_r    <= acc_nxt;
      ended_r  <= ended_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ck_r  <= ck_nxt;
    idm_r <= idm_nxt;
    cmd_r <= cmd_nxt;
    act_r <= act_nxt;
  end

endmodule

### design/ascii_command_frame_decoder_unit.sv
// ascii command frame decoder: top level with configuration registers
//
// Received characters enter on the in_ channel (in_valid, in_stall,
// in_rx_char), one request per cycle while in_stall is low. Frame text up to
// '.' is split on ';' into id high, id low, command and check byte. Each '.'
// produces one request on the out_ channel carrying checksum_ok, id_match,
// command and action; other characters produce none.
// An accepted character is queued and parsed at the queue head; for '.' the
// result is registered in the output register once an output slot is free.
// Sustained rate is one character per cycle while no '.' is held back by
// out_stall. A two-entry queue separates the classifier from the parser, so
// the input keeps being taken while a result waits. If out_stall holds, a
// further '.' waits in the queue; once the queue is full in_stall rises.
// Synchronous reset (rst_n low) clears fields, parse state and the queue
// and loads id_high = 0x12, id_low = 0x80. The id registers are written
// through the APB port at byte addresses 0 and 4; the user must write them
// only while the block is idle, which the block itself does not enforce.
module ascii_command_frame_decoder_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_rx_char,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_checksum_ok,
  output logic        out_id_match,
  output logic [7:0]  out_command,
  output logic [1:0]  out_action,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import acfd_pkg::*;

  logic        sel_high;
  logic [7:0]  id_high_val_r;
  logic [7:0]  id_low_val_r;
  logic        cfg_wr;

  logic        q_full;
  logic        q_push;
  char_class_t q_data;
  logic        q_pop;
  logic        q_head_valid;
  char_class_t q_head;

  assign pready   = 1'b1;
  assign cfg_wr   = psel && penable && pwrite;
  assign sel_high = (paddr[2] == REG_ID_HIGH);
  assign prdata   = {24'd0, sel_high ? id_high_val_r : id_low_val_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      id_high_val_r <= ID_HIGH_RST;
      id_low_val_r  <= ID_LOW_RST;
    end else if (cfg_wr) begin
      if (sel_high) begin
        id_high_val_r <= pwdata[7:0];
      end else begin
        id_low_val_r <= pwdata[7:0];
      end
    end
  end

  acfd_front u_front (
    .in_valid   (in_valid),
    .in_rx_char (in_rx_char),
    .in_stall   (in_stall),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_data     (q_data)
  );

  acfd_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_data  (q_data),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_head_valid),
    .head_data  (q_head)
  );

  acfd_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .head_valid      (q_head_valid),
    .head_data       (q_head),
    .pop             (q_pop),
    .id_high         (id_high_val_r),
    .id_low          (id_low_val_r),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_checksum_ok (out_checksum_ok),
    .out_id_match    (out_id_match),
    .out_command     (out_command),
    .out_action      (out_action)
  );

endmodule
